[sv/bmn16_pkg.sv]
// shared types and constants for the bitonic minimum network block
// no dependencies; used by bmn16_ctrl, bmn16_dp and bitonic_min_network_16_unit
`default_nettype none

package bmn16_pkg;

    // packed word layout
    localparam int WORD_W    = 20;
    localparam int KEY_LSB   = 8;
    localparam int KEY_MAX_W = WORD_W - KEY_LSB;

    // stream data width, rounded up to whole bytes
    localparam int TDATA_W = ((WORD_W + 7) / 8) * 8;

    // log2 of merge block size and distance, covers block sizes up to 128 words
    localparam int LOG_W = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [LOG_W-1:0]  t_log;

    // commands from the controller to the datapath
    typedef struct packed {
        logic shift;       // shift buffer down by one word
        logic pass;        // run one compare-exchange pass
        logic final_xchg;  // exchange first and last word on key
        t_log s_log;       // log2 of merge block size
        t_log d_log;       // log2 of pair distance
    } t_dp_cmd;

endpackage

`default_nettype wire

[sv/bitonic_min_network_16_unit.sv]
// top level of the bitonic minimum network: stream ports, controller and datapath
// depends on bmn16_pkg, bmn16_ctrl and bmn16_dp
`default_nettype none

// The block takes NUM_WORDS 20-bit words, one item per cycle while o_s_tready is high,
// then runs the merge passes of a bitonic network for block sizes 2 up to half the batch,
// one pass per cycle over all pairs at once (six passes for 16 words), then an exchange step
// that exchanges the first and last word so that word 0 holds a minimum key (bits 19:8,
// KEY_WIDTH of them compared). It then emits all words in position order from word 0,
// with o_m_tlast on the last one. Input is not taken while a batch is sorted or emitted,
// since all passes share one word buffer.
module bitonic_min_network_16_unit #(
    parameter int NUM_WORDS = 16,
    parameter int KEY_WIDTH = 12
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input stream
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire  [bmn16_pkg::TDATA_W-1:0]        i_s_tdata,   // [19:0] element
    // output stream
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [bmn16_pkg::TDATA_W-1:0]        o_m_tdata,   // [19:0] element_out
    output logic                                 o_m_tlast
);

    bmn16_pkg::t_dp_cmd w_cmd;
    bmn16_pkg::t_word   w_in_word;
    bmn16_pkg::t_word   w_out_word;

    assign w_in_word = i_s_tdata[bmn16_pkg::WORD_W-1:0];

    // sequencing of load, merge passes, exchange and emit
    bmn16_ctrl #(
        .NUM_WORDS (NUM_WORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_last  (o_m_tlast),
        .o_cmd       (w_cmd)
    );

    // word buffer and compare-exchange cells
    bmn16_dp #(
        .NUM_WORDS (NUM_WORDS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_word (w_in_word),
        .o_word (w_out_word)
    );

    // zero fill to whole bytes
    assign o_m_tdata = bmn16_pkg::TDATA_W'(w_out_word);

endmodule

`default_nettype wire

[sv/bmn16_dp.sv]
// word buffer and compare-exchange cells of the bitonic minimum network
// depends on bmn16_pkg; driven by commands from bmn16_ctrl
`default_nettype none

module bmn16_dp #(
    parameter int NUM_WORDS = 16,
    parameter int KEY_WIDTH = 12
) (
    input  wire                 i_clk,
    input  wire bmn16_pkg::t_dp_cmd i_cmd,
    input  wire bmn16_pkg::t_word   i_word,
    output bmn16_pkg::t_word        o_word
);

    localparam int IDX_W    = $clog2(NUM_WORDS);
    localparam int KEY_BITS = (KEY_WIDTH < bmn16_pkg::KEY_MAX_W) ? KEY_WIDTH
                                                                 : bmn16_pkg::KEY_MAX_W;

    bmn16_pkg::t_word r_buf [NUM_WORDS];
    bmn16_pkg::t_word n_buf [NUM_WORDS];
    bmn16_pkg::t_word w_pass [NUM_WORDS];

    logic [KEY_BITS-1:0] w_key_first;
    logic [KEY_BITS-1:0] w_key_last;

    // one compare-exchange cell per position
    for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
        logic [IDX_W-1:0]    partner;
        logic [IDX_W-1:0]    lo_idx;
        logic                self_lo;
        logic                in_range;
        logic                asc;
        logic                do_swap;
        logic [KEY_BITS-1:0] key_self;
        logic [KEY_BITS-1:0] key_part;
        logic [KEY_BITS-1:0] key_lo;
        logic [KEY_BITS-1:0] key_hi;
        bmn16_pkg::t_word    part_word;

        always_comb begin
            partner  = IDX_W'(k) ^ (IDX_W'(1) << i_cmd.d_log);
            self_lo  = (partner > IDX_W'(k));
            lo_idx   = self_lo ? IDX_W'(k) : partner;
            // pair is skipped when the upper partner lies past the buffer
            in_range = (int'(partner) < NUM_WORDS);
            part_word = in_range ? r_buf[partner] : r_buf[k];
            key_self = r_buf[k][bmn16_pkg::KEY_LSB +: KEY_BITS];
            key_part = part_word[bmn16_pkg::KEY_LSB +: KEY_BITS];
            key_lo   = self_lo ? key_self : key_part;
            key_hi   = self_lo ? key_part : key_self;
            // direction from the lower index of the pair
            asc      = ((lo_idx & (IDX_W'(1) << i_cmd.s_log)) == '0);
            do_swap  = asc ? (key_lo > key_hi) : (key_lo < key_hi);
            w_pass[k] = (in_range && do_swap) ? part_word : r_buf[k];
        end
    end

    assign w_key_first = r_buf[0][bmn16_pkg::KEY_LSB +: KEY_BITS];
    assign w_key_last  = r_buf[NUM_WORDS-1][bmn16_pkg::KEY_LSB +: KEY_BITS];

    // next buffer contents
    always_comb begin
        n_buf = r_buf;
        if (i_cmd.shift) begin
            for (int k = 0; k < NUM_WORDS - 1; k++) begin
                n_buf[k] = r_buf[k+1];
            end
            n_buf[NUM_WORDS-1] = i_word;
        end else if (i_cmd.pass) begin
            n_buf = w_pass;
        end else if (i_cmd.final_xchg) begin
            if (w_key_first > w_key_last) begin
                n_buf[0]           = r_buf[NUM_WORDS-1];
                n_buf[NUM_WORDS-1] = r_buf[0];
            end
        end
    end

    // buffer registers, payload only
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_word = r_buf[0];

endmodule

`default_nettype wire

[sv/bmn16_ctrl.sv]
// controller for the bitonic minimum network: load, merge passes, final exchange, emit
// depends on bmn16_pkg; issues commands to bmn16_dp
`default_nettype none

module bmn16_ctrl #(
    parameter int NUM_WORDS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output logic o_out_last,
    output bmn16_pkg::t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(NUM_WORDS);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_SORT = 4'b0010,
        ST_XCHG = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    bmn16_pkg::t_log      r_s_log, n_s_log;
    bmn16_pkg::t_log      r_d_log, n_d_log;

    logic w_in_acc;
    logic w_out_acc;
    logic w_count_end;
    logic w_more_sizes;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_count_end = (r_count == CNT_W'(NUM_WORDS - 1));
    assign o_out_last  = o_out_valid && w_count_end;

    // another block size follows while twice the current size stays below the batch
    assign w_more_sizes = ((1 << (int'(r_s_log) + 1)) < NUM_WORDS);

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.shift      = w_in_acc || w_out_acc;
        o_cmd.pass       = (r_state == ST_SORT);
        o_cmd.final_xchg = (r_state == ST_XCHG);
        o_cmd.s_log      = r_s_log;
        o_cmd.d_log      = r_d_log;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_s_log = r_s_log;
        n_d_log = r_d_log;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_count_end) begin
                        n_count = '0;
                        n_state = ST_SORT;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_SORT: begin
                if (r_d_log == '0) begin
                    if (w_more_sizes) begin
                        n_s_log = r_s_log + bmn16_pkg::t_log'(1);
                        n_d_log = r_s_log;
                    end else begin
                        n_state = ST_XCHG;
                    end
                end else begin
                    n_d_log = r_d_log - bmn16_pkg::t_log'(1);
                end
            end
            ST_XCHG: begin
                n_s_log = bmn16_pkg::t_log'(1);
                n_d_log = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    if (w_count_end) begin
                        n_count = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_s_log <= bmn16_pkg::t_log'(1);
            r_d_log <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_s_log <= n_s_log;
            r_d_log <= n_d_log;
        end
    end

endmodule

`default_nettype wire

[sim/tb_bitonic_min_network_16_unit.sv]
// self-checking bench for bitonic_min_network_16_unit: batches of 16 words in, partly sorted batch out
// keeps its own model of the truncated bitonic network; depends on bmn16_pkg and the rtl
`timescale 1ns / 100ps

module tb_bitonic_min_network_16_unit;

    localparam int BATCH        = 16;
    localparam int KEY_BITS     = 12;
    localparam int RANDOM_SETS  = 14;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PAD_W        = bmn16_pkg::TDATA_W - bmn16_pkg::WORD_W;

    typedef struct {
        bmn16_pkg::t_word element;
        logic             last;
    } t_sorted_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic [bmn16_pkg::TDATA_W-1:0] s_tdata = '0;   // [19:0] element
    logic                          m_tready = 1'b0;
    logic                          o_s_tready;
    logic                          o_m_tvalid;
    logic [bmn16_pkg::TDATA_W-1:0] o_m_tdata;      // [19:0] element_out
    logic                          o_m_tlast;

    bmn16_pkg::t_word word_stream_q[$];
    t_sorted_word     sorted_words_q[$];
    bmn16_pkg::t_word batch_words[BATCH];
    int               batch_fill = 0;

    logic word_taken = 1'b0;
    int   words_in = 0;
    int   batches_out = 0;
    int   err_cnt = 0;
    int   stall_cycles = 0;
    int   hold_left = 0;
    logic hold_used = 1'b0;
    logic calm;

    bitonic_min_network_16_unit #(
        .NUM_WORDS(BATCH),
        .KEY_WIDTH(KEY_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    // no idling on either side over a middle stretch of the run
    assign calm = (words_in >= 96) && (words_in < 160);

    function automatic logic [KEY_BITS-1:0] word_key(bmn16_pkg::t_word w);
        return w[bmn16_pkg::KEY_LSB +: KEY_BITS];
    endfunction

    // merge passes for sizes 2, 4, 8, then first/last exchange toward the minimum
    function automatic void sort_batch();
        int               p;
        bmn16_pkg::t_word t;
        for (int sz = 2; sz < BATCH; sz = sz << 1) begin
            for (int d = sz >> 1; d > 0; d = d >> 1) begin
                for (int i = 0; i < BATCH; i++) begin
                    p = i ^ d;
                    if (p > i) begin
                        if (((i & sz) == 0) ? (word_key(batch_words[i]) > word_key(batch_words[p]))
                                            : (word_key(batch_words[i]) < word_key(batch_words[p])))
                        begin
                            t = batch_words[i];
                            batch_words[i] = batch_words[p];
                            batch_words[p] = t;
                        end
                    end
                end
            end
        end
        if (word_key(batch_words[0]) > word_key(batch_words[BATCH-1])) begin
            t = batch_words[0];
            batch_words[0] = batch_words[BATCH-1];
            batch_words[BATCH-1] = t;
        end
    endfunction

    // store one word; a full batch is sorted and queued for output
    function automatic void take_word(bmn16_pkg::t_word w);
        t_sorted_word s;
        batch_words[batch_fill] = w;
        batch_fill++;
        if (batch_fill == BATCH) begin
            sort_batch();
            for (int k = 0; k < BATCH; k++) begin
                s.element = batch_words[k];
                s.last    = (k == BATCH - 1);
                sorted_words_q.push_back(s);
            end
            batch_fill = 0;
        end
    endfunction

    // sender: new item on the falling edge once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (word_stream_q.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{PAD_W{1'b0}}, word_stream_q.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off once two batches are out
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && batches_out == 2) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 35);
        end
    end

    // monitor: predict on input items, check output items, watch for a hang
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (s_tvalid && o_s_tready) begin
                words_in <= words_in + 1;
                take_word(s_tdata[bmn16_pkg::WORD_W-1:0]);
            end
            if (o_m_tvalid && m_tready) begin
                if (o_m_tlast)
                    batches_out <= batches_out + 1;
                if (sorted_words_q.size() == 0) begin
                    $error("unexpected output item: element_out %h last %b",
                           o_m_tdata[bmn16_pkg::WORD_W-1:0], o_m_tlast);
                    err_cnt++;
                end else begin
                    if (o_m_tdata[bmn16_pkg::WORD_W-1:0] !== sorted_words_q[0].element) begin
                        $error("element_out: expected %h, got %h",
                               sorted_words_q[0].element, o_m_tdata[bmn16_pkg::WORD_W-1:0]);
                        err_cnt++;
                    end
                    if (o_m_tlast !== sorted_words_q[0].last) begin
                        $error("last: expected %b, got %b", sorted_words_q[0].last, o_m_tlast);
                        err_cnt++;
                    end
                    void'(sorted_words_q.pop_front());
                end
            end
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [KEY_BITS-1:0] keys[BATCH];
        logic [KEY_BITS-1:0] k0;
        int                  kind;

        // directed batch: key extremes, equal keys in both halves, low byte extremes
        keys = '{12'hFFF, 12'h000, 12'h800, 12'h7FF, 12'h800, 12'h123, 12'hFFF, 12'h001,
                 12'hABC, 12'h555, 12'h000, 12'hAAA, 12'h000, 12'hFFE, 12'h800, 12'h3C3};
        for (int k = 0; k < BATCH; k++)
            word_stream_q.push_back({keys[k], (k % 2 == 0) ? 8'hFF : 8'h00});

        // random batches of several shapes
        for (int b = 0; b < RANDOM_SETS; b++) begin
            kind = $urandom_range(4);
            k0   = KEY_BITS'($urandom_range(4095));
            for (int k = 0; k < BATCH; k++) begin
                case (kind)
                    0: keys[k] = KEY_BITS'($urandom_range(4095));
                    1: keys[k] = KEY_BITS'($urandom_range(3));
                    2: keys[k] = k0;
                    3: keys[k] = KEY_BITS'(4095 - k * 16 - int'($urandom_range(15)));
                    default: keys[k] = $urandom_range(1) ? 12'hFFF : 12'h000;
                endcase
                word_stream_q.push_back({keys[k], 8'($urandom_range(255))});
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_stream_q.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (sorted_words_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
sv/bmn16_pkg.sv
sv/bmn16_dp.sv
sv/bmn16_ctrl.sv
sv/bitonic_min_network_16_unit.sv
sim/tb_bitonic_min_network_16_unit.sv
